// ===== rtl/core/sgbi_pkg.sv =====
// sgbi_pkg: shared constants, codes and types of the grid bucket index
// used by the interfaces, the divider, the core and the top level
`default_nettype none
package sgbi_pkg;
	localparam int MAX_NODES = 1024;
	localparam int MAX_CELLS = 4096;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int OFFS_AW   = $clog2(MAX_CELLS + 1);
	localparam int DIM_W     = CELL_W + 1;
	localparam int POS_W     = 13;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int ST_W      = 3;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 3'd0,
		OP_BUILD    = 3'd1,
		OP_RD_OFFS  = 3'd2,
		OP_RD_ENTRY = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_OUTSIDE = 3'd1,
		ST_FULL    = 3'd2,
		ST_CELLS   = 3'd3,
		ST_BAD     = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELL_SIZE = 2'd0,
		CFG_MAX_LAT   = 2'd1,
		CFG_MAX_LON   = 2'd2
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_DIV_A,
		S_DIV_B,
		S_DIV_C,
		S_DIV_D,
		S_ADD_DIM,
		S_ADD_CHK,
		S_ADD_CELL,
		S_ADD_RD,
		S_ADD_WR,
		S_PFX_RD,
		S_PFX_WR,
		S_SC_RD,
		S_SC_OFF,
		S_SC_WR,
		S_RD_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [DATA_W-1:0] node_id;
		logic [DATA_W-1:0] latitude;
		logic [DATA_W-1:0] longitude;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [DATA_W-1:0] value;
		logic [CELL_W-1:0] cell_index;
	} res_t;

	typedef struct packed {
		logic [DATA_W-1:0] cell_size;
		logic [DATA_W-1:0] max_lat;
		logic [DATA_W-1:0] max_lon;
	} cfg_t;
endpackage
`default_nettype wire

// ===== rtl/core/sgbi_if.sv =====
// sgbi_if: valid/ready channels of the grid bucket index
// request, response and register write; widths from sgbi_pkg
`default_nettype none
interface sgbi_req_if;
	logic                         valid;
	logic                         ready;
	logic [sgbi_pkg::OP_W-1:0]    operation;
	logic [sgbi_pkg::DATA_W-1:0]  node_id;
	logic [sgbi_pkg::DATA_W-1:0]  latitude;
	logic [sgbi_pkg::DATA_W-1:0]  longitude;
	logic [sgbi_pkg::POS_W-1:0]   position;
	modport source (output valid, operation, node_id, latitude, longitude, position,
		input ready);
	modport sink (input valid, operation, node_id, latitude, longitude, position,
		output ready);
endinterface

interface sgbi_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [sgbi_pkg::ST_W-1:0]    status;
	logic [sgbi_pkg::DATA_W-1:0]  value;
	logic [sgbi_pkg::CELL_W-1:0]  cell_index;
	modport source (output valid, status, value, cell_index, input ready);
	modport sink (input valid, status, value, cell_index, output ready);
endinterface

interface sgbi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sgbi_pkg::CFG_IDX_W-1:0] index;
	logic [sgbi_pkg::DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sgbi_div.sv =====
// sgbi_div: 32-bit unsigned restoring divider, one quotient bit per cycle
// depends on sgbi_pkg; the user must not start it with a zero divisor, which the divider itself does not enforce
`default_nettype none
module sgbi_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [sgbi_pkg::DATA_W-1:0] dividend,
	input  wire logic [sgbi_pkg::DATA_W-1:0] divisor,
	output logic                             done,
	output logic [sgbi_pkg::DATA_W-1:0]      quotient
);
	localparam int CW = $clog2(sgbi_pkg::DATA_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [sgbi_pkg::DATA_W-1:0] rem_q;
	logic [sgbi_pkg::DATA_W-1:0] quo_q;
	logic [sgbi_pkg::DATA_W-1:0] den_q;
	logic [sgbi_pkg::DATA_W:0]   shifted;
	logic [sgbi_pkg::DATA_W:0]   trial;

	assign shifted = {rem_q, quo_q[sgbi_pkg::DATA_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(sgbi_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[sgbi_pkg::DATA_W]) begin
				rem_q <= trial[sgbi_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sgbi_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[sgbi_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sgbi_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/sgbi_core.sv =====
// sgbi_core: sequencer and memories of the grid bucket index
// node, offset and sorted stores; uses sgbi_pkg and sgbi_div
`default_nettype none
module sgbi_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sgbi_pkg::req_t req,
	input  wire sgbi_pkg::cfg_t cfg,
	output logic               res_valid,
	input  wire logic          res_ready,
	output sgbi_pkg::res_t     res
);
	localparam int NAW = sgbi_pkg::NODE_AW;
	localparam int CW  = sgbi_pkg::CNT_W;
	localparam int EW  = sgbi_pkg::CELL_W;
	localparam int OAW = sgbi_pkg::OFFS_AW;
	localparam int DW  = sgbi_pkg::DIM_W;
	localparam int XW  = sgbi_pkg::DATA_W;

	localparam logic [sgbi_pkg::POS_W-1:0] POS_MAX = sgbi_pkg::POS_W'(sgbi_pkg::MAX_CELLS);

	sgbi_pkg::state_t state_q, state_d;
	sgbi_pkg::req_t   req_q;
	sgbi_pkg::res_t   res_q;

	logic [CW-1:0]  nc_q;
	logic           built_q;
	logic           clr_op_q;
	logic [OAW-1:0] idx_q;
	logic [CW-1:0]  sum_q;
	logic [XW-1:0]  qa_q, qb_q, qc_q, qd_q;
	logic [DW-1:0]  rows_q, cols_q;
	logic           big_q;
	logic [EW-1:0]  cell_q;

	logic [XW-1:0] id_mem   [sgbi_pkg::MAX_NODES];
	logic [EW-1:0] cell_mem [sgbi_pkg::MAX_NODES];
	logic [CW-1:0] offs_mem [sgbi_pkg::MAX_CELLS + 1];
	logic [XW-1:0] sort_mem [sgbi_pkg::MAX_NODES];

	logic [XW-1:0] id_rd_q;
	logic [EW-1:0] cell_rd_q;
	logic [CW-1:0] offs_rd_q;
	logic [XW-1:0] sort_rd_q;

	logic           node_we;
	logic [NAW-1:0] node_ra;
	logic [OAW-1:0] offs_ra;
	logic           offs_we;
	logic [OAW-1:0] offs_wa;
	logic [CW-1:0]  offs_wd;
	logic           sort_we;
	logic [NAW-1:0] sort_wa;
	logic [NAW-1:0] sort_ra;

	logic          div_start;
	logic [XW-1:0] div_dividend;
	logic          div_done;
	logic [XW-1:0] div_quo;

	logic [2*DW-1:0] grid_cells;
	logic            chk_cells;
	logic            chk_out;
	logic            chk_full;
	logic [CW-1:0]   pfx_sum;
	logic            last_node;

	sgbi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg.cell_size),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign grid_cells = rows_q * cols_q;
	assign chk_cells  = big_q || (grid_cells > (2*DW)'(sgbi_pkg::MAX_CELLS));
	assign chk_out    = (qc_q > qa_q) || (qd_q > qb_q);
	assign chk_full   = (nc_q >= CW'(sgbi_pkg::MAX_NODES));
	assign pfx_sum    = sum_q + offs_rd_q;
	assign last_node  = (idx_q == (OAW'(nc_q) - OAW'(1)));

	// next state and memory control
	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		res_valid    = 1'b0;
		node_we      = 1'b0;
		node_ra      = idx_q[NAW-1:0];
		offs_ra      = '0;
		offs_we      = 1'b0;
		offs_wa      = idx_q;
		offs_wd      = '0;
		sort_we      = 1'b0;
		sort_wa      = offs_rd_q[NAW-1:0];
		sort_ra      = req.position[NAW-1:0];
		div_start    = 1'b0;
		div_dividend = cfg.max_lat;
		case (state_q)
			sgbi_pkg::S_CLR: begin
				offs_we = 1'b1;
				if (idx_q == OAW'(sgbi_pkg::MAX_CELLS))
					state_d = clr_op_q ? sgbi_pkg::S_RESP : sgbi_pkg::S_IDLE;
			end
			sgbi_pkg::S_IDLE: begin
				req_ready = 1'b1;
				offs_ra   = req.position - OAW'(1);
				if (req_valid) begin
					case (req.operation)
						sgbi_pkg::OP_ADD: begin
							if (built_q || cfg.cell_size == '0) begin
								state_d = sgbi_pkg::S_RESP;
							end else begin
								div_start = 1'b1;
								state_d   = sgbi_pkg::S_DIV_A;
							end
						end
						sgbi_pkg::OP_BUILD:
							state_d = built_q ? sgbi_pkg::S_RESP : sgbi_pkg::S_PFX_RD;
						sgbi_pkg::OP_RD_OFFS: begin
							if (!built_q || req.position > POS_MAX || req.position == '0)
								state_d = sgbi_pkg::S_RESP;
							else
								state_d = sgbi_pkg::S_RD_WAIT;
						end
						sgbi_pkg::OP_RD_ENTRY: begin
							if (!built_q || req.position >= sgbi_pkg::POS_W'(nc_q))
								state_d = sgbi_pkg::S_RESP;
							else
								state_d = sgbi_pkg::S_RD_WAIT;
						end
						sgbi_pkg::OP_CLEAR: state_d = sgbi_pkg::S_CLR;
						default:            state_d = sgbi_pkg::S_RESP;
					endcase
				end
			end
			sgbi_pkg::S_DIV_A: begin
				div_dividend = cfg.max_lon;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = sgbi_pkg::S_DIV_B;
				end
			end
			sgbi_pkg::S_DIV_B: begin
				div_dividend = req_q.latitude;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = sgbi_pkg::S_DIV_C;
				end
			end
			sgbi_pkg::S_DIV_C: begin
				div_dividend = req_q.longitude;
				if (div_done) begin
					div_start = 1'b1;
					state_d   = sgbi_pkg::S_DIV_D;
				end
			end
			sgbi_pkg::S_DIV_D: begin
				if (div_done)
					state_d = sgbi_pkg::S_ADD_DIM;
			end
			sgbi_pkg::S_ADD_DIM: state_d = sgbi_pkg::S_ADD_CHK;
			sgbi_pkg::S_ADD_CHK: begin
				if (chk_cells || chk_out || chk_full)
					state_d = sgbi_pkg::S_RESP;
				else
					state_d = sgbi_pkg::S_ADD_CELL;
			end
			sgbi_pkg::S_ADD_CELL: state_d = sgbi_pkg::S_ADD_RD;
			sgbi_pkg::S_ADD_RD: begin
				offs_ra = OAW'(cell_q) + OAW'(1);
				node_we = 1'b1;
				state_d = sgbi_pkg::S_ADD_WR;
			end
			sgbi_pkg::S_ADD_WR: begin
				offs_we = 1'b1;
				offs_wa = OAW'(cell_q) + OAW'(1);
				offs_wd = offs_rd_q + CW'(1);
				state_d = sgbi_pkg::S_RESP;
			end
			sgbi_pkg::S_PFX_RD: begin
				offs_ra = idx_q;
				state_d = sgbi_pkg::S_PFX_WR;
			end
			sgbi_pkg::S_PFX_WR: begin
				offs_we = 1'b1;
				offs_wd = pfx_sum;
				if (idx_q != OAW'(sgbi_pkg::MAX_CELLS))
					state_d = sgbi_pkg::S_PFX_RD;
				else if (nc_q == '0)
					state_d = sgbi_pkg::S_RESP;
				else
					state_d = sgbi_pkg::S_SC_RD;
			end
			sgbi_pkg::S_SC_RD: state_d = sgbi_pkg::S_SC_OFF;
			sgbi_pkg::S_SC_OFF: begin
				offs_ra = OAW'(cell_rd_q);
				state_d = sgbi_pkg::S_SC_WR;
			end
			sgbi_pkg::S_SC_WR: begin
				// cursor kept in the offset store itself; it ends one cell ahead
				sort_we = 1'b1;
				offs_we = 1'b1;
				offs_wa = OAW'(cell_rd_q);
				offs_wd = offs_rd_q + CW'(1);
				state_d = last_node ? sgbi_pkg::S_RESP : sgbi_pkg::S_SC_RD;
			end
			sgbi_pkg::S_RD_WAIT: state_d = sgbi_pkg::S_RESP;
			sgbi_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = sgbi_pkg::S_IDLE;
			end
			default: state_d = sgbi_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sgbi_pkg::S_CLR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q     <= '0;
			built_q  <= 1'b0;
			clr_op_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				sgbi_pkg::S_CLR: begin
					idx_q <= idx_q + OAW'(1);
					if (idx_q == OAW'(sgbi_pkg::MAX_CELLS)) begin
						nc_q    <= '0;
						built_q <= 1'b0;
					end
				end
				sgbi_pkg::S_IDLE: begin
					if (req_valid) begin
						clr_op_q <= 1'b1;
						idx_q    <= (req.operation == sgbi_pkg::OP_BUILD) ? OAW'(1) : '0;
					end
				end
				sgbi_pkg::S_ADD_WR: nc_q <= nc_q + CW'(1);
				sgbi_pkg::S_PFX_WR: begin
					if (idx_q != OAW'(sgbi_pkg::MAX_CELLS))
						idx_q <= idx_q + OAW'(1);
					else if (nc_q == '0)
						built_q <= 1'b1;
					else
						idx_q <= '0;
				end
				sgbi_pkg::S_SC_WR: begin
					idx_q <= idx_q + OAW'(1);
					if (last_node)
						built_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			sgbi_pkg::S_CLR: res_q <= '{sgbi_pkg::ST_OK, '0, '0};
			sgbi_pkg::S_IDLE: begin
				req_q <= req;
				sum_q <= '0;
				res_q <= '{sgbi_pkg::ST_OK, '0, '0};
				case (req.operation)
					sgbi_pkg::OP_ADD: begin
						if (built_q)
							res_q.status <= sgbi_pkg::ST_BAD;
						else if (cfg.cell_size == '0)
							res_q.status <= sgbi_pkg::ST_CELLS;
					end
					sgbi_pkg::OP_BUILD, sgbi_pkg::OP_CLEAR: ;
					sgbi_pkg::OP_RD_OFFS: begin
						if (!built_q || req.position > POS_MAX)
							res_q.status <= sgbi_pkg::ST_BAD;
					end
					sgbi_pkg::OP_RD_ENTRY: begin
						if (!built_q || req.position >= sgbi_pkg::POS_W'(nc_q))
							res_q.status <= sgbi_pkg::ST_BAD;
					end
					default: res_q.status <= sgbi_pkg::ST_BAD;
				endcase
			end
			sgbi_pkg::S_DIV_A: if (div_done) qa_q <= div_quo;
			sgbi_pkg::S_DIV_B: if (div_done) qb_q <= div_quo;
			sgbi_pkg::S_DIV_C: if (div_done) qc_q <= div_quo;
			sgbi_pkg::S_DIV_D: if (div_done) qd_q <= div_quo;
			sgbi_pkg::S_ADD_DIM: begin
				rows_q <= DW'(qa_q[EW-1:0]) + DW'(1);
				cols_q <= DW'(qb_q[EW-1:0]) + DW'(1);
				big_q  <= (qa_q[XW-1:EW] != '0) || (qb_q[XW-1:EW] != '0);
			end
			sgbi_pkg::S_ADD_CHK: begin
				if (chk_cells)
					res_q.status <= sgbi_pkg::ST_CELLS;
				else if (chk_out)
					res_q.status <= sgbi_pkg::ST_OUTSIDE;
				else if (chk_full)
					res_q.status <= sgbi_pkg::ST_FULL;
			end
			sgbi_pkg::S_ADD_CELL: begin
				cell_q <= EW'(DW'(qc_q[EW-1:0]) * cols_q + DW'(qd_q[EW-1:0]));
			end
			sgbi_pkg::S_ADD_WR: res_q.cell_index <= cell_q;
			sgbi_pkg::S_PFX_WR: sum_q <= pfx_sum;
			sgbi_pkg::S_RD_WAIT: begin
				if (req_q.operation == sgbi_pkg::OP_RD_OFFS)
					res_q.value <= XW'(offs_rd_q);
				else
					res_q.value <= sort_rd_q;
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (node_we) begin
			id_mem[nc_q[NAW-1:0]]   <= req_q.node_id;
			cell_mem[nc_q[NAW-1:0]] <= cell_q;
		end
		id_rd_q   <= id_mem[node_ra];
		cell_rd_q <= cell_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (offs_we)
			offs_mem[offs_wa] <= offs_wd;
		offs_rd_q <= offs_mem[offs_ra];
	end

	always_ff @(posedge clk) begin
		if (sort_we)
			sort_mem[sort_wa] <= id_rd_q;
		sort_rd_q <= sort_mem[sort_ra];
	end

	assign res = res_q;
endmodule
`default_nettype wire

// ===== rtl/core/spatial_grid_bucket_index.sv =====
// spatial_grid_bucket_index: top level of the uniform-grid bucket index
// register file, response register and assertions; uses sgbi_pkg, sgbi_if, sgbi_core
//
// Channels: req takes one operation per beat (add, build, read offset, read list
// entry, clear); rsp returns exactly one beat per request; cfg writes cell_size,
// max_latitude, max_longitude and is always ready. The user must make cfg writes
// only while no request is in flight; the block itself does not enforce this.
// One request is in work at a time. Steps of add and build, set by the sequencer:
//   add          four divisions on one shared divider
//   build        a prefix pass over the offset memory, then one scatter step
//                per stored node
// After arst_n the offset memory is cleared in a pass during which req.ready
// stays low; cfg writes are taken as ever.
// The response sits in an output register: a new request is accepted while it
// waits, and the sequencer holds its next result until rsp takes the beat.
`default_nettype none
module spatial_grid_bucket_index (
	input  wire logic clk,
	input  wire logic arst_n,
	sgbi_req_if.sink  req,
	sgbi_rsp_if.source rsp,
	sgbi_cfg_if.sink  cfg
);
	sgbi_pkg::cfg_t cfg_q;
	sgbi_pkg::req_t req_pl;
	sgbi_pkg::res_t core_res;
	sgbi_pkg::res_t out_q;
	logic           out_valid_q;
	logic           core_valid;
	logic           core_ready;
	logic           req_rdy;

	assign req_pl = '{req.operation, req.node_id, req.latitude, req.longitude,
		req.position};

	sgbi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_rdy),
		.req       (req_pl),
		.cfg       (cfg_q),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	assign req.ready  = req_rdy;
	assign cfg.ready  = 1'b1;
	assign core_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{sgbi_pkg::DATA_W'(1048576), '0, '0};
		end else if (cfg.valid) begin
			case (cfg.index)
				sgbi_pkg::CFG_CELL_SIZE: cfg_q.cell_size <= cfg.data;
				sgbi_pkg::CFG_MAX_LAT:   cfg_q.max_lat   <= cfg.data;
				sgbi_pkg::CFG_MAX_LON:   cfg_q.max_lon   <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (core_valid && core_ready)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (core_valid && core_ready)
			out_q <= core_res;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.value      = out_q.value;
	assign rsp.cell_index = out_q.cell_index;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= sgbi_pkg::ST_BAD)
		else $error("response status out of range");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != sgbi_pkg::ST_OK |-> rsp.value == '0 && rsp.cell_index == '0)
		else $error("refused request carries data");
`endif
endmodule
`default_nettype wire

// ===== tb/sgbi_checker.sv =====
// sgbi_checker: watches the request, response and register channels of the grid index,
// keeps its own copy of the index state and compares every response beat in order
// depends on sgbi_pkg and the channel interfaces in sgbi_if
module sgbi_checker
	import sgbi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sgbi_req_if  req,
	sgbi_rsp_if  rsp,
	sgbi_cfg_if  cfg,
	output int   errors,
	output int   pending,
	output int   n_ok,
	output int   n_refused
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0] cell_size, max_lat, max_lon;
	int unsigned       node_count;
	logic [DATA_W-1:0] ids [MAX_NODES];
	int unsigned       cells [MAX_NODES];
	int unsigned       offsets [MAX_CELLS+1];
	int unsigned       cursor [MAX_CELLS+1];
	logic [DATA_W-1:0] sorted [MAX_NODES];
	bit                built;
	res_t              awaited [$];

	function automatic status_t grid_add(input logic [DATA_W-1:0] id,
		input logic [DATA_W-1:0] lat, input logic [DATA_W-1:0] lon,
		output logic [CELL_W-1:0] cell_out);
		longint unsigned rows, cols, row, col, cell_no;
		cell_out = '0;
		if (built) return ST_BAD;
		if (cell_size == 0) return ST_CELLS;
		rows = longint'(max_lat / cell_size) + 1;
		cols = longint'(max_lon / cell_size) + 1;
		if (rows > MAX_CELLS || cols > MAX_CELLS || rows * cols > MAX_CELLS)
			return ST_CELLS;
		row = lat / cell_size;
		col = lon / cell_size;
		if (row >= rows || col >= cols) return ST_OUTSIDE;
		if (node_count >= MAX_NODES) return ST_FULL;
		cell_no = row * cols + col;
		ids[node_count] = id;
		cells[node_count] = int'(cell_no);
		node_count++;
		offsets[cell_no+1]++;
		cell_out = cell_no[CELL_W-1:0];
		return ST_OK;
	endfunction

	function automatic void grid_build();
		int unsigned sum;
		sum = 0;
		if (built) return;
		for (int i = 1; i <= MAX_CELLS; i++) begin
			sum += offsets[i];
			offsets[i] = sum;
		end
		cursor = offsets;
		for (int i = 0; i < node_count; i++) begin
			sorted[cursor[cells[i]]] = ids[i];
			cursor[cells[i]]++;
		end
		built = 1;
	endfunction

	function automatic res_t grid_response(input logic [OP_W-1:0] op,
		input logic [DATA_W-1:0] id, input logic [DATA_W-1:0] lat,
		input logic [DATA_W-1:0] lon, input logic [POS_W-1:0] pos);
		res_t r;
		logic [CELL_W-1:0] c;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_ADD: begin
				r.status = grid_add(id, lat, lon, c);
				r.cell_index = c;
			end
			OP_BUILD: grid_build();
			OP_RD_OFFS: begin
				if (!built || pos > MAX_CELLS) r.status = ST_BAD;
				else r.value = offsets[pos];
			end
			OP_RD_ENTRY: begin
				if (!built || pos >= node_count) r.status = ST_BAD;
				else r.value = sorted[pos];
			end
			OP_CLEAR: begin
				node_count = 0;
				foreach (offsets[i]) offsets[i] = 0;
				built = 0;
			end
			default: r.status = ST_BAD;
		endcase
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		n_ok = 0;
		n_refused = 0;
		cell_size = 32'h0010_0000;
		max_lat = '0;
		max_lon = '0;
		node_count = 0;
		built = 0;
		foreach (offsets[i]) offsets[i] = 0;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_CELL_SIZE: cell_size = cfg.data;
					CFG_MAX_LAT:   max_lat = cfg.data;
					CFG_MAX_LON:   max_lon = cfg.data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					$error("response beat with nothing awaited");
					errors++;
				end else begin
					want = awaited.pop_front();
					if (rsp.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.value !== want.value) begin
						$error("value expected %0h got %0h", want.value, rsp.value);
						errors++;
					end
					if (rsp.cell_index !== want.cell_index) begin
						$error("cell_index expected %0d got %0d", want.cell_index,
							rsp.cell_index);
						errors++;
					end
					if (want.status == ST_OK) n_ok++;
					else n_refused++;
				end
			end
			if (req.valid && req.ready)
				awaited.push_back(grid_response(req.operation, req.node_id, req.latitude,
					req.longitude, req.position));
		end
		pending = awaited.size();
	end
endmodule

// ===== tb/tb.sv =====
// tb: drives the grid bucket index with directed and random operations per grid setting
// and gives the verdict; depends on sgbi_pkg, sgbi_if, sgbi_checker and the block
module tb;
	import sgbi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending, n_ok, n_refused;
	int   sent = 0;
	int   hold_left = 0;
	int   quiet = 0;
	logic [DATA_W-1:0] cur_lat, cur_lon;
	int   adds_in_set;

	sgbi_req_if req();
	sgbi_rsp_if rsp();
	sgbi_cfg_if cfg();

	spatial_grid_bucket_index i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	sgbi_checker i_checker (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending), .n_ok(n_ok), .n_refused(n_refused));

	always #6 clk = ~clk;

	function automatic int send_idle_pct();
		if (sent < 380) return 30;
		if (sent < 760) return 45;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (sent < 380) return 45;
		if (sent < 760) return 30;
		return 0;
	endfunction

	// receiver with random stalls and long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
		else quiet++;
		if (quiet >= 60000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] id,
		input logic [DATA_W-1:0] lat, input logic [DATA_W-1:0] lon,
		input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct()) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.node_id <= id;
		req.latitude <= lat;
		req.longitude <= lon;
		req.position <= pos;
		do @(posedge clk); while (!req.ready);
		sent++;
		if (op == OP_ADD) adds_in_set++;
		@(negedge clk);
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic set_grid(input logic [DATA_W-1:0] cs, input logic [DATA_W-1:0] ml,
		input logic [DATA_W-1:0] mo);
		settle();
		write_reg(CFG_CELL_SIZE, cs);
		write_reg(CFG_MAX_LAT, ml);
		write_reg(CFG_MAX_LON, mo);
		cfg.valid <= 1'b0;
		cur_lat = ml;
		cur_lon = mo;
	endtask

	function automatic logic [DATA_W-1:0] coord(input logic [DATA_W-1:0] lim,
		input bit in_range);
		if (in_range || $urandom_range(99) < 85) return $urandom_range(lim, 0);
		return $urandom;
	endfunction

	task automatic add_node(input bit in_range);
		send(OP_ADD, $urandom, coord(cur_lat, in_range), coord(cur_lon, in_range),
			POS_W'($urandom));
	endtask

	task automatic read_any();
		logic [POS_W-1:0] p;
		case ($urandom_range(5))
			0: p = POS_W'($urandom);
			1: p = POS_W'(MAX_CELLS - $urandom_range(2));
			default: p = POS_W'($urandom_range(adds_in_set + 1));
		endcase
		send($urandom_range(1) ? OP_RD_OFFS : OP_RD_ENTRY, $urandom, $urandom, $urandom, p);
	endtask

	// one build cycle: clear, adds with some noise unless clean, build, reads
	task automatic grid_set(input int n_adds, input int n_reads, input bit long_hold,
		input bit clean);
		adds_in_set = 0;
		send(OP_CLEAR, $urandom, $urandom, $urandom, POS_W'($urandom));
		adds_in_set = 0;
		for (int i = 0; i < n_adds; i++) begin
			if (clean) begin
				add_node(1'b1);
			end else begin
				case ($urandom_range(19))
					0: read_any();
					1: send(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom,
						POS_W'($urandom));
					default: add_node(1'b0);
				endcase
			end
			if (long_hold && i == n_adds / 2) hold_left = 400;
		end
		send(OP_BUILD, $urandom, $urandom, $urandom, POS_W'($urandom));
		for (int i = 0; i < n_reads; i++) begin
			case ($urandom_range(19))
				0: add_node(1'b0);
				1: send(OP_BUILD, $urandom, $urandom, $urandom, POS_W'($urandom));
				default: read_any();
			endcase
		end
	endtask

	initial begin
		req.valid = 0;
		req.operation = '0;
		req.node_id = '0;
		req.latitude = '0;
		req.longitude = '0;
		req.position = '0;
		rsp.ready = 0;
		cfg.valid = 0;
		cfg.index = CFG_CELL_SIZE;
		cfg.data = '0;
		cur_lat = '0;
		cur_lon = '0;
		adds_in_set = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset grid: a single cell
		send(OP_RD_OFFS, 0, 0, 0, 0);
		send(OP_ADD, 32'hFFFF_FFFF, 0, 0, 0);
		send(OP_ADD, 32'h0000_0001, 32'h000F_FFFF, 32'h000F_FFFF, 0);
		send(OP_ADD, 32'h1234_5678, 32'h0010_0000, 0, 0);
		send(OP_ADD, 32'h1234_5678, 0, 32'hFFFF_FFFF, 0);
		send(OP_RD_ENTRY, 0, 0, 0, 0);
		send(OP_BUILD, 0, 0, 0, 0);
		send(OP_BUILD, 0, 0, 0, 0);
		send(OP_RD_OFFS, 0, 0, 0, 0);
		send(OP_RD_OFFS, 0, 0, 0, 1);
		send(OP_RD_OFFS, 0, 0, 0, 13'd4096);
		send(OP_RD_OFFS, 0, 0, 0, 13'd4097);
		send(OP_RD_OFFS, 0, 0, 0, 13'h1FFF);
		send(OP_RD_ENTRY, 0, 0, 0, 0);
		send(OP_RD_ENTRY, 0, 0, 0, 1);
		send(OP_RD_ENTRY, 0, 0, 0, 2);
		send(OP_ADD, 7, 0, 0, 0);
		send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'h1FFF);
		send(OP_CLEAR, 0, 0, 0, 0);
		send(OP_BUILD, 0, 0, 0, 0);
		send(OP_RD_OFFS, 0, 0, 0, 13'd4096);
		send(OP_RD_ENTRY, 0, 0, 0, 0);
		send(OP_CLEAR, 0, 0, 0, 0);

		// zero cell size, then a grid far too large
		set_grid(0, 0, 0);
		send(OP_ADD, 1, 0, 0, 0);
		set_grid(1, 32'hFFFF_FFFF, 0);
		send(OP_ADD, 2, 0, 0, 0);

		// widest grid: 64 by 64 cells of the smallest size
		set_grid(1, 63, 63);
		grid_set(16, 8, 1'b1, 1'b0);
		// largest cell size, two by two
		set_grid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		grid_set(6, 4, 1'b0, 1'b0);
		// one column of 4096 rows
		set_grid(3, 4095 * 3 + 2, 2);
		grid_set(8, 4, 1'b0, 1'b0);
		// store filled past its end on a 4 by 4 grid
		set_grid(32'h0010_0000, 32'h0030_0000, 32'h0030_0000);
		grid_set(1026, 6, 1'b1, 1'b1);
		// random moderate grids
		repeat (2) begin
			set_grid($urandom_range(32'h0001_0000, 32'h0004_0000),
				$urandom_range(40 * 32'h0001_0000), $urandom_range(40 * 32'h0001_0000));
			grid_set(5, 3, 1'b0, 1'b0);
		end
		set_grid(0, $urandom, $urandom);
		grid_set(3, 2, 1'b0, 1'b0);

		settle();
		repeat (50) @(negedge clk);
		$display("covered %0d operations over several grid settings: %0d answered ok, %0d refused",
			sent, n_ok, n_refused);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
